@@ src/cei_pkg.sv @@
// shared types, constants and helpers for the complete elliptic integral block
// no dependencies; imported by cei_alu and complete_elliptic_integral
package cei_pkg;

  localparam int CEI_MAX_LANDEN_STEPS = 16;

  localparam int MOD_W   = 32;
  localparam int OUT_W   = 32;
  localparam int STEPS_W = 5;
  localparam int LIMIT_W = 21;
  localparam int ALU_A_W = 64;
  localparam int ALU_B_W = 33;
  localparam int ALU_P_W = 70;
  localparam int LOG_BITS = 30;

  localparam logic [31:0] ONE_Q31     = 32'h8000_0000;
  localparam logic [62:0] ONE_SQ_Q62  = 63'h4000_0000_0000_0000;
  localparam logic [36:0] PROD_CAP    = 37'h10_0000_0000;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] LN2_Q31     = 32'd1488522236;
  localparam logic [35:0] ONE_Q30     = 36'h0_4000_0000;

  // configuration register indexes
  localparam logic CFG_LANDEN_STEPS = 1'b0;
  localparam logic CFG_SMALL_LIMIT  = 1'b1;

  typedef enum logic [1:0] {
    ALU_MUL  = 2'd0,
    ALU_SQRT = 2'd1,
    ALU_DIV  = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic                 start;
    alu_op_t              op;
    logic [ALU_A_W-1:0]   a;
    logic [ALU_B_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [ALU_P_W-1:0]   result;
  } alu_rsp_t;

  // round q30 to q8.24 and saturate
  function automatic logic [OUT_W-1:0] q30_to_out(input logic [39:0] v);
    logic [40:0] sum;
    logic [34:0] r;
    sum = {1'b0, v} + 41'd32;
    r   = sum[40:6];
    if (r[34:32] != 3'd0) begin
      return '1;
    end
    return r[31:0];
  endfunction

endpackage

@@ src/cei_alu.sv @@
// shared arithmetic unit: split multiply, bit-serial square root and divide
// depends on cei_pkg
module cei_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  cei_pkg::alu_req_t req,
  output cei_pkg::alu_rsp_t rsp
);
  import cei_pkg::*;

  localparam int ITER  = 32;
  localparam int CNT_W = 6;

  alu_op_t          op_r;
  logic [63:0]      a_r;
  logic [32:0]      b_r;
  logic [34:0]      rem_r;
  logic [31:0]      root_r;
  logic [69:0]      acc_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [30:0] mx;
  logic [63:0] mprod;
  logic [34:0] r2s, trial, r2d, dv;
  logic        ges, ged;

  // one 31x33 multiplier, low part first then high part
  assign mx    = cnt_r[0] ? {25'd0, a_r[36:31]} : a_r[30:0];
  assign mprod = {33'd0, mx} * {31'd0, b_r};

  // root digit and quotient bit trials
  assign r2s   = {rem_r[32:0], a_r[63:62]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ges   = r2s >= trial;
  assign r2d   = {rem_r[33:0], a_r[63]};
  assign dv    = {2'b00, b_r};
  assign ged   = r2d >= dv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        op_r   <= req.op;
        b_r    <= req.b;
        cnt_r  <= '0;
        busy_r <= 1'b1;
        root_r <= '0;
        if (req.op == ALU_DIV) begin
          rem_r <= {3'd0, req.a[63:32]};
          a_r   <= {req.a[31:0], 32'd0};
        end else begin
          rem_r <= '0;
          a_r   <= req.a;
        end
      end else if (busy_r) begin
        case (op_r)
          ALU_MUL: begin
            if (cnt_r == '0) begin
              acc_r <= {6'd0, mprod};
              cnt_r <= CNT_W'(1);
            end else begin
              acc_r  <= acc_r + {mprod[38:0], 31'd0};
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          ALU_SQRT: begin
            if (ges) begin
              rem_r  <= r2s - trial;
              root_r <= {root_r[30:0], 1'b1};
            end else begin
              rem_r  <= r2s;
              root_r <= {root_r[30:0], 1'b0};
            end
            a_r   <= {a_r[61:0], 2'b00};
            cnt_r <= cnt_r + CNT_W'(1);
            if (cnt_r == CNT_W'(ITER - 1)) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          ALU_DIV: begin
            if (ged) begin
              rem_r  <= r2d - dv;
              root_r <= {root_r[30:0], 1'b1};
            end else begin
              rem_r  <= r2d;
              root_r <= {root_r[30:0], 1'b0};
            end
            a_r   <= {a_r[62:0], 1'b0};
            cnt_r <= cnt_r + CNT_W'(1);
            if (cnt_r == CNT_W'(ITER - 1)) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          default: begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        endcase
      end
    end
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = (op_r == ALU_MUL) ? acc_r : {38'd0, root_r};

endmodule

@@ src/complete_elliptic_integral.sv @@
// Complete elliptic integrals K(k) and K'(k) from a Q1.31 modulus, Q8.24 results.
// Every multiply, square root and divide runs on one shared unit (cei_alu); a square
// root or divide produces one bit a cycle. An integral is found by Landen steps, or
// by the logarithmic form near a singular end. The block takes one request at a
// time and is not ready until its result has been taken.
// depends on cei_pkg and cei_alu
module complete_elliptic_integral #(
  parameter int MAX_LANDEN_STEPS = cei_pkg::CEI_MAX_LANDEN_STEPS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cei_pkg::MOD_W-1:0]     in_modulus,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cei_pkg::OUT_W-1:0]     out_integral_k,
  output logic [cei_pkg::OUT_W-1:0]     out_integral_k_complement,
  output logic                          out_k_infinite,
  output logic                          out_k_complement_infinite,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [cei_pkg::LIMIT_W-1:0]   cfg_wdata
);
  import cei_pkg::*;

  localparam int CNT_W = $clog2(MAX_LANDEN_STEPS + 1);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_REMSQ  = 16'h0002,
    S_KMINSQ = 16'h0004,
    S_KPROOT = 16'h0008,
    S_SEL    = 16'h0010,
    S_LSQ    = 16'h0020,
    S_LROOT  = 16'h0040,
    S_LDIV   = 16'h0080,
    S_LQSQ   = 16'h0100,
    S_LPROD  = 16'h0200,
    S_LFIN   = 16'h0400,
    S_GNORM  = 16'h0800,
    S_GSQR   = 16'h1000,
    S_GLN    = 16'h2000,
    S_GMSQ   = 16'h4000,
    S_GCOR   = 16'h8000
  } state_t;

  state_t             state_r;
  logic               issued_r;
  logic [STEPS_W-1:0] steps_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [31:0]        k_r, kp_r, m_r, s_r, mant_r;
  logic [62:0]        rem_r;
  logic               asym_k_r;
  logic               which_r;
  logic [36:0]        prod_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [29:0]        frac_r;
  logic [4:0]         shift_r;
  logic [4:0]         iter_r;
  logic [35:0]        lval_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_k_r, out_kc_r;
  logic               out_kinf_r, out_kcinf_r;

  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;

  logic [69:0]        p;
  logic               done;
  logic [CNT_W-1:0]   steps_eff;
  logic [35:0]        lm1, n_val;
  logic [32:0]        t_sq;
  logic [63:0]        m_round;
  logic [36:0]        prod_nxt;
  logic [22:0]        sq_cap;
  logic               fin_en;
  logic [OUT_W-1:0]   fin_val;
  logic               accept;

  cei_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign p        = alu_rsp.result;
  assign done     = issued_r && alu_rsp.done;
  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE) && !out_valid_r;

  // effective step count
  always_comb begin
    if (steps_r == '0) begin
      steps_eff = CNT_W'(1);
    end else if (32'(steps_r) > 32'(MAX_LANDEN_STEPS)) begin
      steps_eff = CNT_W'(MAX_LANDEN_STEPS);
    end else begin
      steps_eff = CNT_W'(steps_r);
    end
  end

  // datapath helpers on the unit result
  assign lm1      = (lval_r > ONE_Q30) ? (lval_r - ONE_Q30) : '0;
  assign n_val    = {6'(6'd2 + {1'b0, shift_r}), 30'd0} - {6'd0, frac_r};
  assign t_sq     = p[63:31];
  assign m_round  = p[63:0] + 64'h0000_0000_4000_0000;
  assign prod_nxt = (p[69:31] > {2'b00, PROD_CAP}) ? PROD_CAP : p[67:31];
  assign sq_cap   = (p[63:20] > 44'h40_0000) ? 23'h40_0000 : p[42:20];

  // integral finished
  always_comb begin
    fin_en  = 1'b0;
    fin_val = '0;
    unique case (state_r)
      S_LFIN: begin
        fin_en  = done;
        fin_val = q30_to_out({1'b0, p[69:31]});
      end
      S_GCOR: begin
        fin_en  = done;
        fin_val = q30_to_out(40'(lval_r) + 40'(p[69:44]));
      end
      S_GNORM: begin
        fin_en  = (m_r == '0);
        fin_val = '1;
      end
      default: begin
        fin_en  = 1'b0;
        fin_val = '0;
      end
    endcase
  end

  // request to the shared unit
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = ALU_MUL;
    alu_req.a     = '0;
    alu_req.b     = '0;
    unique case (state_r)
      S_REMSQ: begin
        alu_req.a = 64'(k_r);
        alu_req.b = 33'(k_r);
      end
      S_KMINSQ: begin
        alu_req.a = 64'(limit_r);
        alu_req.b = 33'(limit_r);
      end
      S_KPROOT, S_LROOT: begin
        alu_req.op = ALU_SQRT;
        alu_req.a  = {1'b0, rem_r};
      end
      S_LSQ, S_GMSQ: begin
        alu_req.a = 64'(m_r);
        alu_req.b = 33'(m_r);
      end
      S_LDIV: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = {1'b0, m_r, 31'd0};
        alu_req.b  = {1'b0, ONE_Q31} + {1'b0, s_r};
      end
      S_LQSQ: begin
        alu_req.a = 64'(s_r);
        alu_req.b = 33'(s_r);
      end
      S_LPROD: begin
        alu_req.a = 64'(prod_r);
        alu_req.b = {1'b0, ONE_Q31} + {1'b0, m_r};
      end
      S_LFIN: begin
        alu_req.a = 64'(prod_r);
        alu_req.b = 33'(HALF_PI_Q30);
      end
      S_GSQR: begin
        alu_req.a = 64'(mant_r);
        alu_req.b = 33'(mant_r);
      end
      S_GLN: begin
        alu_req.a = 64'(n_val);
        alu_req.b = 33'(LN2_Q31);
      end
      S_GCOR: begin
        alu_req.a = 64'(lm1);
        alu_req.b = 33'(s_r);
      end
      default: begin
        alu_req.a = '0;
      end
    endcase
    if (state_r != S_IDLE && state_r != S_SEL && state_r != S_GNORM) begin
      alu_req.start = !issued_r;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= STEPS_W'(8);
      limit_r <= LIMIT_W'(2147);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LANDEN_STEPS: steps_r <= cfg_wdata[STEPS_W-1:0];
        CFG_SMALL_LIMIT:  limit_r <= cfg_wdata;
        default:          steps_r <= steps_r;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      which_r     <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (alu_req.start) begin
        issued_r <= 1'b1;
      end else if (done) begin
        issued_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            k_r     <= (in_modulus > ONE_Q31) ? ONE_Q31 : in_modulus;
            which_r <= 1'b0;
            state_r <= S_REMSQ;
          end
        end
        S_REMSQ: begin
          if (done) begin
            rem_r   <= ONE_SQ_Q62 - p[62:0];
            state_r <= S_KMINSQ;
          end
        end
        S_KMINSQ: begin
          if (done) begin
            asym_k_r <= rem_r < p[62:0];
            state_r  <= S_KPROOT;
          end
        end
        S_KPROOT: begin
          if (done) begin
            kp_r    <= p[31:0];
            state_r <= S_SEL;
          end
        end
        S_SEL: begin
          if (!which_r) begin
            if (k_r == ONE_Q31) begin
              out_k_r    <= '1;
              out_kinf_r <= 1'b1;
              which_r    <= 1'b1;
            end else begin
              out_kinf_r <= 1'b0;
              if (asym_k_r) begin
                m_r     <= kp_r;
                mant_r  <= kp_r;
                shift_r <= '0;
                frac_r  <= '0;
                iter_r  <= '0;
                state_r <= S_GNORM;
              end else begin
                m_r     <= k_r;
                prod_r  <= 37'(ONE_Q31);
                cnt_r   <= '0;
                state_r <= S_LSQ;
              end
            end
          end else begin
            if (k_r == '0) begin
              out_kc_r    <= '1;
              out_kcinf_r <= 1'b1;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              out_kcinf_r <= 1'b0;
              if (k_r < 32'(limit_r)) begin
                m_r     <= k_r;
                mant_r  <= k_r;
                shift_r <= '0;
                frac_r  <= '0;
                iter_r  <= '0;
                state_r <= S_GNORM;
              end else begin
                m_r     <= kp_r;
                prod_r  <= 37'(ONE_Q31);
                cnt_r   <= '0;
                state_r <= S_LSQ;
              end
            end
          end
        end
        // landen step
        S_LSQ: begin
          if (done) begin
            rem_r   <= ONE_SQ_Q62 - p[62:0];
            state_r <= S_LROOT;
          end
        end
        S_LROOT: begin
          if (done) begin
            s_r     <= p[31:0];
            state_r <= S_LDIV;
          end
        end
        S_LDIV: begin
          if (done) begin
            s_r     <= p[31:0];
            state_r <= S_LQSQ;
          end
        end
        S_LQSQ: begin
          if (done) begin
            m_r     <= m_round[62:31];
            state_r <= S_LPROD;
          end
        end
        S_LPROD: begin
          if (done) begin
            prod_r <= prod_nxt;
            cnt_r  <= cnt_r + CNT_W'(1);
            if (cnt_r + CNT_W'(1) == steps_eff) begin
              state_r <= S_LFIN;
            end else begin
              state_r <= S_LSQ;
            end
          end
        end
        S_LFIN: begin
          state_r <= S_LFIN;
        end
        // logarithmic form: normalize, square for log2 bits, scale by ln2, square m and correct
        S_GNORM: begin
          if (m_r != '0) begin
            if (mant_r[31]) begin
              state_r <= S_GSQR;
            end else begin
              mant_r  <= {mant_r[30:0], 1'b0};
              shift_r <= shift_r + 5'd1;
            end
          end
        end
        S_GSQR: begin
          if (done) begin
            if (t_sq[32]) begin
              mant_r <= t_sq[32:1];
              frac_r <= {frac_r[28:0], 1'b1};
            end else begin
              mant_r <= t_sq[31:0];
              frac_r <= {frac_r[28:0], 1'b0};
            end
            iter_r <= iter_r + 5'd1;
            if (iter_r == 5'(LOG_BITS - 1)) begin
              state_r <= S_GLN;
            end
          end
        end
        S_GLN: begin
          if (done) begin
            lval_r  <= p[66:31];
            state_r <= S_GMSQ;
          end
        end
        S_GMSQ: begin
          if (done) begin
            s_r     <= 32'(sq_cap);
            state_r <= S_GCOR;
          end
        end
        S_GCOR: begin
          state_r <= S_GCOR;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      // store a finished integral
      if (fin_en) begin
        if (!which_r) begin
          out_k_r <= fin_val;
          which_r <= 1'b1;
          state_r <= S_SEL;
        end else begin
          out_kc_r    <= fin_val;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
      end
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_integral_k            = out_k_r;
  assign out_integral_k_complement = out_kc_r;
  assign out_k_infinite            = out_kinf_r;
  assign out_k_complement_infinite = out_kcinf_r;

`ifndef SYNTHESIS
  a_alu_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    alu_req.start |-> !alu_rsp.busy)
    else $error("shared unit started while busy");

  a_prod_capped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LFIN) |-> (prod_r <= PROD_CAP))
    else $error("landen product above cap");

  a_inf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kinf_r) |-> (out_k_r == '1))
    else $error("infinite K not saturated");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_REMSQ) && !out_valid_r)
    else $error("request accepted while busy");
`endif

endmodule
